FILE: rtl/core/gsm_pkg.sv
// Shared constants, types and the quarter-wave sine table of the oscillator bank.
`timescale 1ns / 1ps
package gsm_pkg;

	// bank size and sample format
	localparam int VOICES       = 4;
	localparam int SINE_ENTRIES = 256;
	localparam int SAMPLE_BITS  = 16;

	localparam int VOICE_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int ISSUE_SLOTS = (VOICES > 1) ? VOICES : 2;
	localparam int SINE_IDX_W  = $clog2(SINE_ENTRIES);
	localparam int AMP_W       = SAMPLE_BITS - 1;
	localparam int ACC_W       = SAMPLE_BITS + VOICE_W;

	// fixed field widths
	localparam int STEP_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int OUT_W      = 16;
	localparam int ENABLE_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd5;

	// register reset values
	localparam logic [STEP_W-1:0]  RST_TARGET_A = 32'd42852281;
	localparam logic [STEP_W-1:0]  RST_TARGET_B = 32'd64278422;
	localparam logic [STEP_W-1:0]  RST_TARGET_C = 32'd108469837;
	localparam logic [STEP_W-1:0]  RST_TARGET_D = 32'd162704755;
	localparam logic [LEVEL_W-1:0] RST_PAN      = 16'd16384;
	localparam logic [LEVEL_W-1:0] RST_GAIN     = 16'd1638;

	// glide: step = (step*KEEP + target*TAKE) >> 16
	localparam logic [15:0] GLIDE_KEEP = 16'd62259;
	localparam logic [11:0] GLIDE_TAKE = 12'd3277;
	localparam logic [LEVEL_W-1:0] FULL_Q15 = 16'd32768;
	localparam int SCALE_SHIFT = SAMPLE_BITS + 14;

	// result queue depth, also the limit of items in flight
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);

	typedef logic [STEP_W-1:0] step_t;
	typedef step_t [3:0] target_set_t;

	// classified input item
	typedef struct packed {
		logic                glide;
		logic [ENABLE_W-1:0] enable;
	} cmd_t;

	// per-channel voice sums of one item
	typedef struct packed {
		logic signed [ACC_W-1:0] left;
		logic signed [ACC_W-1:0] right;
	} mix_t;

	// finished stereo sample
	typedef struct packed {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
	} sample_t;

	// mixing controls from the register file
	typedef struct packed {
		logic [LEVEL_W-1:0] pan;
		logic [LEVEL_W-1:0] gain;
	} mix_ctrl_t;

	// voice number to register slot (voice mod 4)
	function automatic logic [1:0] slot_of(input logic [VOICE_W-1:0] voice);
		return 2'(voice);
	endfunction

	// quarter-wave table, built at elaboration from a Q28 Taylor series
	localparam logic [63:0] PI_Q28  = 64'd843314857;
	localparam logic [63:0] AMP_MAX = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

	function automatic logic [AMP_W-1:0] sine_entry(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        v;
		x    = (PI_Q28 * (64'(k) * 64'd2 + 64'd1)) / (4 * SINE_ENTRIES);
		x2   = (x * x) >> 28;
		term = x;
		acc  = $signed(x);
		term = ((term * x2) >> 28) / 64'd6;   acc = acc - $signed(term);
		term = ((term * x2) >> 28) / 64'd20;  acc = acc + $signed(term);
		term = ((term * x2) >> 28) / 64'd42;  acc = acc - $signed(term);
		term = ((term * x2) >> 28) / 64'd72;  acc = acc + $signed(term);
		term = ((term * x2) >> 28) / 64'd110; acc = acc - $signed(term);
		term = ((term * x2) >> 28) / 64'd156; acc = acc + $signed(term);
		term = ((term * x2) >> 28) / 64'd210; acc = acc - $signed(term);
		term = ((term * x2) >> 28) / 64'd272; acc = acc + $signed(term);
		if (acc < 0) begin
			acc = '0;
		end
		v = ($unsigned(acc) * AMP_MAX + (64'd1 << 27)) >> 28;
		if (v > AMP_MAX) begin
			v = AMP_MAX;
		end
		return v[AMP_W-1:0];
	endfunction

	typedef logic [AMP_W-1:0] sine_rom_t [SINE_ENTRIES];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			rom[k] = sine_entry(k);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/core/gsm_cmd_queue.sv
// Front end: takes input transactions, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module gsm_cmd_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          buffer_start,
	input  logic [gsm_pkg::ENABLE_W-1:0]  voice_enable,
	output logic                          cmd_valid,
	output gsm_pkg::cmd_t                 cmd,
	input  logic                          cmd_ready
);
	import gsm_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// classify: a buffer start asks for a glide before the sample
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q].glide  <= buffer_start;
			slot_q[wr_ptr_q].enable <= voice_enable;
		end
	end

endmodule

FILE: rtl/core/gsm_voice_engine.sv
// Back end: one shared glide / phase / sine pipeline stepped through the voices of each item.
`timescale 1ns / 1ps
module gsm_voice_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  gsm_pkg::cmd_t         cmd,
	output logic                  cmd_ready,
	input  logic                  room,
	input  gsm_pkg::target_set_t  targets,
	output logic                  mix_valid,
	output gsm_pkg::mix_t         mix
);
	import gsm_pkg::*;

	localparam logic [VOICE_W-1:0] LAST_SLOT  = VOICE_W'(ISSUE_SLOTS - 1);
	localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);
	localparam logic [VOICE_W:0]   VOICE_CNT  = (VOICE_W + 1)'(VOICES);

	// voice state
	step_t step_q  [VOICES];
	step_t phase_q [VOICES];

	// sequencer
	logic               busy_q;
	logic [VOICE_W-1:0] cnt_q;
	cmd_t               cmd_q;
	logic               at_end;
	logic               take;
	logic               issue;
	logic [1:0]         slot;

	// stage 1: glide products
	logic               valid_s1;
	logic [VOICE_W-1:0] voice_s1;
	logic               glide_s1;
	logic               en_s1;
	logic               right_s1;
	logic               first_s1;
	logic               last_s1;
	step_t              step_s1;
	logic [47:0]        keep_s1;
	logic [43:0]        take_s1;

	// stage 2: new step
	logic               valid_s2;
	logic [VOICE_W-1:0] voice_s2;
	logic               en_s2;
	logic               right_s2;
	logic               first_s2;
	logic               last_s2;
	step_t              step_s2;
	logic [48:0]        glide_sum;
	step_t              step_next;

	// stage 3: phase advance
	logic               valid_s3;
	logic               en_s3;
	logic               right_s3;
	logic               first_s3;
	logic               last_s3;
	step_t              phase_s3;
	step_t              phase_next;

	// stage 4: table lookup
	logic                    valid_s4;
	logic                    right_s4;
	logic                    first_s4;
	logic                    last_s4;
	logic signed [ACC_W-1:0] sine_s4;
	logic [SINE_IDX_W+1:0]   lut_pos;
	logic [SINE_IDX_W-1:0]   lut_idx;
	logic [AMP_W-1:0]        lut_mag;
	logic signed [ACC_W-1:0] lut_val;

	// stage 5: channel sums
	logic signed [ACC_W-1:0] acc_l_q;
	logic signed [ACC_W-1:0] acc_r_q;
	logic signed [ACC_W-1:0] acc_l_next;
	logic signed [ACC_W-1:0] acc_r_next;

	// sequencer: one voice per cycle, next item loaded on the last slot
	assign at_end    = (cnt_q == LAST_SLOT);
	assign cmd_ready = room && (!busy_q || at_end);
	assign take      = cmd_valid && cmd_ready;
	assign issue     = busy_q && ({1'b0, cnt_q} < VOICE_CNT);
	assign slot      = slot_of(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + VOICE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
		end
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			mix_valid <= 1'b0;
		end else begin
			valid_s1  <= issue;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			mix_valid <= valid_s4 && last_s4;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		voice_s1 <= cnt_q;
		glide_s1 <= cmd_q.glide;
		en_s1    <= cmd_q.enable[slot];
		right_s1 <= slot[1];
		first_s1 <= (cnt_q == '0);
		last_s1  <= (cnt_q == LAST_VOICE);
		step_s1  <= step_q[cnt_q];
		keep_s1  <= step_q[cnt_q] * GLIDE_KEEP;
		take_s1  <= targets[slot] * GLIDE_TAKE;
	end

	// stage 2
	assign glide_sum = 49'(keep_s1) + 49'(take_s1);
	assign step_next = glide_s1 ? glide_sum[47:16] : step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				step_q[v] <= '0;
			end
		end else if (valid_s1) begin
			step_q[voice_s1] <= step_next;
		end
	end

	always_ff @(posedge clk) begin
		voice_s2 <= voice_s1;
		en_s2    <= en_s1;
		right_s2 <= right_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		step_s2  <= step_next;
	end

	// stage 3
	assign phase_next = phase_q[voice_s2] + step_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				phase_q[v] <= '0;
			end
		end else if (valid_s2) begin
			phase_q[voice_s2] <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		en_s3    <= en_s2;
		right_s3 <= right_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		phase_s3 <= phase_next;
	end

	// stage 4: quadrant fold of the quarter-wave table
	assign lut_pos = phase_s3[STEP_W-1 -: SINE_IDX_W + 2];
	assign lut_idx = lut_pos[SINE_IDX_W] ? ~lut_pos[SINE_IDX_W-1:0] : lut_pos[SINE_IDX_W-1:0];
	assign lut_mag = SINE_ROM[lut_idx];

	always_comb begin
		lut_val = $signed(ACC_W'(lut_mag));
		if (lut_pos[SINE_IDX_W+1]) begin
			lut_val = -lut_val;
		end
		if (!en_s3) begin
			lut_val = '0;
		end
	end

	always_ff @(posedge clk) begin
		right_s4 <= right_s3;
		first_s4 <= first_s3;
		last_s4  <= last_s3;
		sine_s4  <= lut_val;
	end

	// stage 5: sums restart on the first voice, hand off on the last
	always_comb begin
		acc_l_next = first_s4 ? '0 : acc_l_q;
		acc_r_next = first_s4 ? '0 : acc_r_q;
		if (right_s4) begin
			acc_r_next = acc_r_next + sine_s4;
		end else begin
			acc_l_next = acc_l_next + sine_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			acc_l_q <= acc_l_next;
			acc_r_q <= acc_r_next;
		end
		if (valid_s4 && last_s4) begin
			mix.left  <= acc_l_next;
			mix.right <= acc_r_next;
		end
	end

endmodule

FILE: rtl/core/gsm_mixer.sv
// Back end: gain and pan scaling of the channel sums, rounding and 16-bit saturation.
`timescale 1ns / 1ps
module gsm_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mix_valid,
	input  gsm_pkg::mix_t       mix,
	input  gsm_pkg::mix_ctrl_t  ctrl,
	output logic                smp_valid,
	output gsm_pkg::sample_t    smp
);
	import gsm_pkg::*;

	localparam int P1_W = ACC_W + LEVEL_W;
	localparam int P2_W = P1_W + LEVEL_W;
	localparam int R_W  = P2_W + 1 - SCALE_SHIFT;
	localparam logic [P2_W:0]  ROUND_BIAS = (P2_W + 1)'(1) << (SCALE_SHIFT - 1);
	localparam logic [R_W-1:0] POS_LIMIT  = R_W'(32767);
	localparam logic [R_W-1:0] NEG_LIMIT  = R_W'(32768);
	localparam logic [OUT_W-1:0] POS_SAT  = 16'h7FFF;
	localparam logic [OUT_W-1:0] NEG_SAT  = 16'h8000;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	// stage 1: magnitude, sign and pan weights
	logic [ACC_W-1:0]   mag_l_s1;
	logic [ACC_W-1:0]   mag_r_s1;
	logic               neg_l_s1;
	logic               neg_r_s1;
	logic [LEVEL_W-1:0] wl_s1;
	logic [LEVEL_W-1:0] wr_s1;
	logic [LEVEL_W-1:0] gain_s1;
	logic [LEVEL_W-1:0] pan_lim;

	// stage 2: times gain
	logic [P1_W-1:0]    p1_l_s2;
	logic [P1_W-1:0]    p1_r_s2;
	logic               neg_l_s2;
	logic               neg_r_s2;
	logic [LEVEL_W-1:0] wl_s2;
	logic [LEVEL_W-1:0] wr_s2;

	// stage 3: times weight
	logic [P2_W-1:0] p2_l_s3;
	logic [P2_W-1:0] p2_r_s3;
	logic            neg_l_s3;
	logic            neg_r_s3;

	// stage 4: round and saturate
	logic [P2_W:0]    rnd_l;
	logic [P2_W:0]    rnd_r;
	logic [R_W-1:0]   r_l;
	logic [R_W-1:0]   r_r;
	logic [OUT_W-1:0] sat_l;
	logic [OUT_W-1:0] sat_r;

	assign pan_lim = (ctrl.pan > FULL_Q15) ? FULL_Q15 : ctrl.pan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			smp_valid <= 1'b0;
		end else begin
			valid_s1  <= mix_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			smp_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		mag_l_s1 <= mix.left[ACC_W-1] ? ACC_W'(-mix.left) : ACC_W'(mix.left);
		mag_r_s1 <= mix.right[ACC_W-1] ? ACC_W'(-mix.right) : ACC_W'(mix.right);
		neg_l_s1 <= mix.left[ACC_W-1];
		neg_r_s1 <= mix.right[ACC_W-1];
		wl_s1    <= FULL_Q15 - pan_lim;
		wr_s1    <= pan_lim;
		gain_s1  <= ctrl.gain;
	end

	always_ff @(posedge clk) begin
		p1_l_s2  <= P1_W'(mag_l_s1) * P1_W'(gain_s1);
		p1_r_s2  <= P1_W'(mag_r_s1) * P1_W'(gain_s1);
		neg_l_s2 <= neg_l_s1;
		neg_r_s2 <= neg_r_s1;
		wl_s2    <= wl_s1;
		wr_s2    <= wr_s1;
	end

	always_ff @(posedge clk) begin
		p2_l_s3  <= P2_W'(p1_l_s2) * P2_W'(wl_s2);
		p2_r_s3  <= P2_W'(p1_r_s2) * P2_W'(wr_s2);
		neg_l_s3 <= neg_l_s2;
		neg_r_s3 <= neg_r_s2;
	end

	// round half away from zero on the magnitude, then clamp
	assign rnd_l = (P2_W + 1)'(p2_l_s3) + ROUND_BIAS;
	assign rnd_r = (P2_W + 1)'(p2_r_s3) + ROUND_BIAS;
	assign r_l   = rnd_l[P2_W -: R_W];
	assign r_r   = rnd_r[P2_W -: R_W];

	always_comb begin
		if (neg_l_s3) begin
			sat_l = (r_l > NEG_LIMIT) ? NEG_SAT : OUT_W'(~r_l + R_W'(1));
		end else begin
			sat_l = (r_l > POS_LIMIT) ? POS_SAT : OUT_W'(r_l);
		end
		if (neg_r_s3) begin
			sat_r = (r_r > NEG_LIMIT) ? NEG_SAT : OUT_W'(~r_r + R_W'(1));
		end else begin
			sat_r = (r_r > POS_LIMIT) ? POS_SAT : OUT_W'(r_r);
		end
	end

	always_ff @(posedge clk) begin
		smp.left  <= $signed(sat_l);
		smp.right <= $signed(sat_r);
	end

endmodule

FILE: rtl/core/gsm_result_queue.sv
// Output queue holding finished samples until they are popped.
`timescale 1ns / 1ps
module gsm_result_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            smp_valid,
	input  gsm_pkg::sample_t                smp,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [gsm_pkg::OUT_W-1:0] left_sample,
	output logic signed [gsm_pkg::OUT_W-1:0] right_sample
);
	import gsm_pkg::*;

	sample_t              entry_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [CREDIT_W-1:0]  count_q;
	logic                 do_pop;

	assign empty        = (count_q == '0);
	assign do_pop       = pop && !empty;
	assign left_sample  = entry_q[rd_ptr_q].left;
	assign right_sample = entry_q[rd_ptr_q].right;

	// pointers and fill level; the credit scheme upstream keeps this from overflowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (smp_valid) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			unique case ({smp_valid, do_pop})
				2'b10:   count_q <= count_q + CREDIT_W'(1);
				2'b01:   count_q <= count_q - CREDIT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (smp_valid) begin
			entry_q[wr_ptr_q] <= smp;
		end
	end

endmodule

FILE: rtl/core/four_voice_gliding_sine_mixer_unit.sv
// Top level: register file, flow credit and the front / back parts of the oscillator bank.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | push / full       | buffer_start, voice_enable
//  result   | empty / pop       | left_sample, right_sample
//  config   | cfg_we            | cfg_idx, cfg_wdata (write only)
//
// The shared glide/phase/sine pipeline handles one voice per cycle, taking the next item
// on the last voice slot when credit allows, so items overlap in the pipeline.
// Reset loads the register defaults, zeroes all phases and steps and empties the queues.
// Up to 4 samples may be in flight or waiting; the back end stops taking items when that
// many are outstanding, and the input queue holds 2 more before full rises.
`timescale 1ns / 1ps
module four_voice_gliding_sine_mixer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 buffer_start,
	input  logic [gsm_pkg::ENABLE_W-1:0]         voice_enable,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [gsm_pkg::OUT_W-1:0]     left_sample,
	output logic signed [gsm_pkg::OUT_W-1:0]     right_sample,
	input  logic                                 cfg_we,
	input  logic [gsm_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [gsm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import gsm_pkg::*;

	target_set_t         targets_q;
	mix_ctrl_t           ctrl_q;
	logic [CREDIT_W-1:0] inflight_q;
	logic                room;
	logic                cmd_valid;
	cmd_t                cmd;
	logic                cmd_ready;
	logic                cmd_take;
	logic                res_pop;
	logic                mix_valid;
	mix_t                mix;
	logic                smp_valid;
	sample_t             smp;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			targets_q[0] <= RST_TARGET_A;
			targets_q[1] <= RST_TARGET_B;
			targets_q[2] <= RST_TARGET_C;
			targets_q[3] <= RST_TARGET_D;
			ctrl_q.pan   <= RST_PAN;
			ctrl_q.gain  <= RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TARGET_A: targets_q[0] <= cfg_wdata;
				REG_TARGET_B: targets_q[1] <= cfg_wdata;
				REG_TARGET_C: targets_q[2] <= cfg_wdata;
				REG_TARGET_D: targets_q[3] <= cfg_wdata;
				REG_PAN:      ctrl_q.pan   <= cfg_wdata[LEVEL_W-1:0];
				REG_GAIN:     ctrl_q.gain  <= cfg_wdata[LEVEL_W-1:0];
				default:      ctrl_q       <= ctrl_q;
			endcase
		end
	end

	// items taken by the back end but not yet popped
	assign cmd_take = cmd_valid && cmd_ready;
	assign res_pop  = pop && !empty;
	assign room     = (inflight_q < CREDIT_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			unique case ({cmd_take, res_pop})
				2'b10:   inflight_q <= inflight_q + CREDIT_W'(1);
				2'b01:   inflight_q <= inflight_q - CREDIT_W'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	gsm_cmd_queue u_cmd_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.buffer_start (buffer_start),
		.voice_enable (voice_enable),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_ready    (cmd_ready)
	);

	gsm_voice_engine u_voice_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.room      (room),
		.targets   (targets_q),
		.mix_valid (mix_valid),
		.mix       (mix)
	);

	gsm_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.mix_valid (mix_valid),
		.mix       (mix),
		.ctrl      (ctrl_q),
		.smp_valid (smp_valid),
		.smp       (smp)
	);

	gsm_result_queue u_result_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp_valid    (smp_valid),
		.smp          (smp),
		.empty        (empty),
		.pop          (pop),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

endmodule
